// ===== rtl/core/falu_pkg.sv =====
`default_nettype none
package falu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracBitsDefault = 8;

  typedef enum logic [3:0] {
    OpAdd     = 4'd0,
    OpSub     = 4'd1,
    OpMul     = 4'd2,
    OpDiv     = 4'd3,
    OpGt      = 4'd4,
    OpLt      = 4'd5,
    OpGe      = 4'd6,
    OpLe      = 4'd7,
    OpEq      = 4'd8,
    OpNe      = 4'd9,
    OpMin     = 4'd10,
    OpMax     = 4'd11,
    OpInc     = 4'd12,
    OpDec     = 4'd13,
    OpFromInt = 4'd14,
    OpToInt   = 4'd15
  } falu_op_e;

  // Per-request control and side data that rides along the divider chain
  typedef struct packed {
    logic             is_div;
    logic             dz;
    logic             neg;
    logic             cmp;
    logic [WordW-1:0] res;
    logic [WordW-1:0] divisor;
    logic [WordW-1:0] rem;
  } falu_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/falu_div_cell.sv =====
`default_nettype none
// One restoring-division step: brings down one dividend bit, retires one quotient bit
module falu_div_cell #(
  parameter int unsigned DivW = 40
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire falu_pkg::falu_ctl_t  ctl_i,
  input  wire logic [DivW-1:0]      rq_i,
  output logic                      valid_o,
  output falu_pkg::falu_ctl_t       ctl_o,
  output logic [DivW-1:0]           rq_o
);

  logic                            valid_q;
  falu_pkg::falu_ctl_t             ctl_q, ctl_d;
  logic [DivW-1:0]                 rq_q, rq_d;
  logic [falu_pkg::WordW:0]        rem_sh;
  logic [falu_pkg::WordW+1:0]      diff;
  logic                            fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh = {ctl_i.rem, rq_i[DivW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, ctl_i.divisor};
    fits   = ~diff[falu_pkg::WordW+1];
    ctl_d  = ctl_i;
    rq_d   = rq_i;
    if (ctl_i.is_div) begin
      ctl_d.rem = fits ? diff[falu_pkg::WordW-1:0] : rem_sh[falu_pkg::WordW-1:0];
      rq_d      = {rq_i[DivW-2:0], fits};
    end
  end

  // Advance with the rest of the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_d;
      rq_q  <= rq_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rq_o    = rq_q;

endmodule
`default_nettype wire

// ===== rtl/core/fixed_point_alu.sv =====
`default_nettype none
// Signed fixed-point ALU on 32-bit raw words with FRAC_BITS fraction bits.
// Every operation flows through the same pipeline: an input stage (which also
// holds the 32x32 multiplier), a chain of 32+FRAC_BITS division cells that
// each retire one quotient bit, and an output register. One request is accepted
// per cycle while the pipeline is not stalled, and results leave in order. The
// whole pipeline stalls only when the output register is full and not taken.
// Divide by zero gives 0 with divide_by_zero.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = falu_pkg::FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // mode[3:0], operand_a[35:4], operand_b[67:36]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // result_word[31:0], compare_true[32],
                                           // divide_by_zero[33]
);

  localparam int unsigned W    = falu_pkg::WordW;
  localparam int unsigned DivW = W + FRAC_BITS;

  logic                      advance;
  logic [3:0]                mode;
  logic signed [W-1:0]       op_a, op_b;
  logic signed [2*W-1:0]     prod;
  logic [W-1:0]              mag_a, mag_b;
  falu_pkg::falu_ctl_t       front_ctl;
  logic [DivW-1:0]           front_rq;
  logic                      lt_ab, lt_ba;

  logic                      valid_c [0:DivW];
  falu_pkg::falu_ctl_t       ctl_c   [0:DivW];
  logic [DivW-1:0]           rq_c    [0:DivW];

  logic                      out_valid_q;
  logic [W+1:0]              out_q, out_d;
  logic [W-1:0]              quot;

  assign advance       = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = advance;

  assign mode = s_axis_tdata[3:0];
  assign op_a = s_axis_tdata[35:4];
  assign op_b = s_axis_tdata[67:36];

  // Decode the request and work out everything but the quotient
  always_comb begin
    prod  = op_a * op_b;
    lt_ab = op_a < op_b;
    lt_ba = op_b < op_a;
    mag_a = op_a[W-1] ? W'(-op_a) : W'(op_a);
    mag_b = op_b[W-1] ? W'(-op_b) : W'(op_b);
    front_ctl         = '0;
    front_ctl.divisor = mag_b;
    front_ctl.neg     = op_a[W-1] ^ op_b[W-1];
    front_rq          = {mag_a, {FRAC_BITS{1'b0}}};
    case (falu_pkg::falu_op_e'(mode))
      falu_pkg::OpAdd:     front_ctl.res = W'(op_a + op_b);
      falu_pkg::OpSub:     front_ctl.res = W'(op_a - op_b);
      falu_pkg::OpMul:     front_ctl.res = prod[FRAC_BITS +: W];
      falu_pkg::OpDiv: begin
        front_ctl.is_div = 1'b1;
        front_ctl.dz     = (op_b == '0);
      end
      falu_pkg::OpGt:      front_ctl.cmp = lt_ba;
      falu_pkg::OpLt:      front_ctl.cmp = lt_ab;
      falu_pkg::OpGe:      front_ctl.cmp = ~lt_ab;
      falu_pkg::OpLe:      front_ctl.cmp = ~lt_ba;
      falu_pkg::OpEq:      front_ctl.cmp = (op_a == op_b);
      falu_pkg::OpNe:      front_ctl.cmp = (op_a != op_b);
      falu_pkg::OpMin:     front_ctl.res = lt_ab ? op_a : op_b;
      falu_pkg::OpMax:     front_ctl.res = lt_ba ? op_a : op_b;
      falu_pkg::OpInc:     front_ctl.res = W'(op_a + W'(1));
      falu_pkg::OpDec:     front_ctl.res = W'(op_a - W'(1));
      falu_pkg::OpFromInt: front_ctl.res = W'(op_a <<< FRAC_BITS);
      falu_pkg::OpToInt:   front_ctl.res = W'(op_a >>> FRAC_BITS);
      default:             front_ctl.res = '0;
    endcase
  end

  // Input stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c[0] <= 1'b0;
    end else if (advance) begin
      valid_c[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl_c[0] <= front_ctl;
      rq_c[0]  <= front_rq;
    end
  end

  // Division chain, one quotient bit per cell
  for (genvar k = 0; k < DivW; k++) begin : g_cell
    falu_div_cell #(
      .DivW(DivW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .valid_i(valid_c[k]),
      .ctl_i  (ctl_c[k]),
      .rq_i   (rq_c[k]),
      .valid_o(valid_c[k+1]),
      .ctl_o  (ctl_c[k+1]),
      .rq_o   (rq_c[k+1])
    );
  end

  // Apply sign and divide-by-zero, then pick the result word
  always_comb begin
    quot = rq_c[DivW][W-1:0];
    if (ctl_c[DivW].is_div) begin
      if (ctl_c[DivW].dz) begin
        out_d = {1'b1, 1'b0, {W{1'b0}}};
      end else begin
        out_d = {1'b0, 1'b0, (ctl_c[DivW].neg ? W'(-quot) : quot)};
      end
    end else begin
      out_d = {1'b0, ctl_c[DivW].cmp, ctl_c[DivW].res};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_c[DivW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q};

endmodule
`default_nettype wire
